// File: rtl/core/i8opa_pkg.sv
// ----------------------------------------------------------------------------
// i8opa_pkg
// Shared types, codes and helpers for the int8 outer product accumulator.
// ----------------------------------------------------------------------------
package i8opa_pkg;

   localparam logic [1:0] KIND_ACC   = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   localparam logic [1:0] OP_ACC   = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   typedef struct packed {
      logic              valid;
      logic [1:0]        code;
      logic [3:0]        col;
      logic signed [8:0] a_val;
   } cell_op_type;

   function automatic logic signed [8:0] lane_value(input logic [63:0] lo,
                                                    input logic [63:0] hi,
                                                    input logic [5:0]  idx,
                                                    input logic        sgn);
      logic [7:0] byte_v;
      byte_v = 8'h00;
      if (idx < 6'd8) begin
         byte_v = lo[{idx[2:0], 3'b000} +: 8];
      end else if (idx < 6'd16) begin
         byte_v = hi[{idx[2:0], 3'b000} +: 8];
      end
      return {sgn & byte_v[7], byte_v};
   endfunction

endpackage

// File: rtl/core/i8opa_cell.sv
// ----------------------------------------------------------------------------
// i8opa_cell
// One column of the accumulator grid: a local accumulator memory, a byte
// multiplier and a read-modify-write stage, passing each row beat onward.
// ----------------------------------------------------------------------------
module i8opa_cell #(
   parameter int CELL_IDX = 0,
   parameter int DEPTH    = 64,
   parameter int ADDR_W   = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  i8opa_pkg::cell_op_type  in_op,
   input  logic [ADDR_W-1:0]       in_addr,
   input  logic signed [8:0]       b_val,
   input  logic [31:0]             res_in,
   output i8opa_pkg::cell_op_type  out_op,
   output logic [ADDR_W-1:0]       out_addr,
   output logic [31:0]             res_out
);

   logic [31:0]            mem [DEPTH];
   i8opa_pkg::cell_op_type pass_ff;
   i8opa_pkg::cell_op_type op2_ff;
   logic [ADDR_W-1:0]      addr1_ff;
   logic [ADDR_W-1:0]      addr2_ff;
   logic [31:0]            rdata_ff;
   logic signed [17:0]     prod_ff;
   logic [31:0]            res_ff;
   logic [31:0]            sum_in;
   logic                   hit_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_ff.valid <= 1'b0;
         op2_ff.valid  <= 1'b0;
      end else begin
         pass_ff <= in_op;
         op2_ff  <= in_op;
      end
   end

   always_ff @(posedge clock) begin
      addr1_ff <= in_addr;
      addr2_ff <= in_addr;
      rdata_ff <= mem[in_addr];
      prod_ff  <= in_op.a_val * b_val;
      res_ff   <= hit_in ? rdata_ff : res_in;
   end

   assign sum_in = rdata_ff + 32'(prod_ff);
   assign hit_in = op2_ff.valid && (op2_ff.code == i8opa_pkg::OP_READ) &&
                   (CELL_IDX < 16) && (op2_ff.col == 4'(CELL_IDX));

   always_ff @(posedge clock) begin
      if (op2_ff.valid && (op2_ff.code == i8opa_pkg::OP_ACC)) begin
         mem[addr2_ff] <= sum_in;
      end else if (op2_ff.valid && (op2_ff.code == i8opa_pkg::OP_CLEAR)) begin
         mem[addr2_ff] <= '0;
      end
   end

   assign out_op   = pass_ff;
   assign out_addr = addr1_ff;
   assign res_out  = res_ff;

endmodule

// File: rtl/core/int8_outer_product_accumulate.sv
// ----------------------------------------------------------------------------
// int8_outer_product_accumulate
// Tiles of 32-bit accumulators updated by int8 outer products.
//
// A command beat is taken when start is high and busy is low. Accumulate adds
// a[i]*b[j] into every cell of the chosen tile, read returns one cell, clear
// zeroes a tile. Every command returns exactly one beat on rsp_strobe and
// rsp_value, held for one cycle; the receiver cannot stall it.
// A row of VECTOR_LEN column cells does the work. The controller feeds one
// row per cycle into the first cell, and each row ripples one cell per cycle
// down the chain, each cell doing a read-modify-write on its own memory.
// Accumulate and clear issue VECTOR_LEN rows, read and other kinds issue one.
// The response is given at the end of the wait state that follows the last
// row issued. Busy drops on the edge that ends the response cycle, so the
// next command can start the cycle after.
// After reset the block clears every tile, issuing TILE_COUNT*VECTOR_LEN rows
// and then draining through the wait state, and stays busy meanwhile.
// ----------------------------------------------------------------------------
module int8_outer_product_accumulate #(
   parameter int VECTOR_LEN = 16,
   parameter int TILE_COUNT = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_kind,
   input  logic [1:0]         req_tile,
   input  logic [63:0]        req_a_low,
   input  logic [63:0]        req_a_high,
   input  logic [63:0]        req_b_low,
   input  logic [63:0]        req_b_high,
   input  logic               req_a_signed,
   input  logic               req_b_signed,
   input  logic [3:0]         req_row,
   input  logic [3:0]         req_col,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_value
);

   localparam int ROW_W  = $clog2(VECTOR_LEN);
   localparam int DEPTH  = TILE_COUNT * VECTOR_LEN;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int WAIT_W = $clog2(VECTOR_LEN + 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_WAIT  = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [ADDR_W-1:0] step_ff, step_in;
   logic [ADDR_W-1:0] last_ff, last_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [WAIT_W-1:0] wait_ff, wait_in;
   logic [1:0]        code_ff, code_in;
   logic              live_ff, live_in;
   logic              respond_ff, respond_in;
   logic              read_ff, read_in;
   logic [63:0]       a_low_ff, a_high_ff, b_low_ff, b_high_ff;
   logic              a_sgn_ff, b_sgn_ff;
   logic [3:0]        col_ff;

   logic              accept;
   logic              tile_ok;
   logic              last_step;
   logic              wait_done;
   logic [ADDR_W-1:0] tile_base;

   i8opa_pkg::cell_op_type op_chain   [VECTOR_LEN];
   logic [ADDR_W-1:0]      addr_chain [VECTOR_LEN];
   logic [31:0]            res_chain  [VECTOR_LEN+1];

   assign accept    = start && (state_ff == ST_IDLE);
   assign tile_ok   = (32'(req_tile) < TILE_COUNT);
   assign tile_base = ADDR_W'(32'(req_tile) * VECTOR_LEN);
   assign last_step = (step_ff == last_ff);
   assign wait_done = (wait_ff == WAIT_W'(VECTOR_LEN));

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      last_in    = last_ff;
      base_in    = base_ff;
      wait_in    = wait_ff;
      code_in    = code_ff;
      live_in    = live_ff;
      respond_in = respond_ff;
      read_in    = read_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in   = ST_ISSUE;
               step_in    = '0;
               respond_in = 1'b1;
               read_in    = (req_kind == i8opa_pkg::KIND_READ);
               base_in    = tile_base;
               last_in    = ADDR_W'(VECTOR_LEN - 1);
               unique case (req_kind)
                  i8opa_pkg::KIND_ACC: begin
                     code_in = i8opa_pkg::OP_ACC;
                     live_in = tile_ok;
                  end
                  i8opa_pkg::KIND_CLEAR: begin
                     code_in = i8opa_pkg::OP_CLEAR;
                     live_in = tile_ok;
                  end
                  i8opa_pkg::KIND_READ: begin
                     code_in = i8opa_pkg::OP_READ;
                     live_in = tile_ok && (32'(req_row) < VECTOR_LEN);
                     base_in = ADDR_W'(32'(req_tile) * VECTOR_LEN + 32'(req_row));
                     last_in = '0;
                  end
                  default: begin
                     code_in = i8opa_pkg::OP_READ;
                     live_in = 1'b0;
                     last_in = '0;
                  end
               endcase
            end
         end
         ST_ISSUE: begin
            step_in = step_ff + 1'b1;
            if (last_step) begin
               state_in = ST_WAIT;
               wait_in  = '0;
            end
         end
         ST_WAIT: begin
            wait_in = wait_ff + 1'b1;
            if (wait_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_ISSUE;
         step_ff    <= '0;
         last_ff    <= ADDR_W'(DEPTH - 1);
         base_ff    <= '0;
         wait_ff    <= '0;
         code_ff    <= i8opa_pkg::OP_CLEAR;
         live_ff    <= 1'b1;
         respond_ff <= 1'b0;
         read_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         step_ff    <= step_in;
         last_ff    <= last_in;
         base_ff    <= base_in;
         wait_ff    <= wait_in;
         code_ff    <= code_in;
         live_ff    <= live_in;
         respond_ff <= respond_in;
         read_ff    <= read_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_low_ff  <= req_a_low;
         a_high_ff <= req_a_high;
         b_low_ff  <= req_b_low;
         b_high_ff <= req_b_high;
         a_sgn_ff  <= req_a_signed;
         b_sgn_ff  <= req_b_signed;
         col_ff    <= req_col;
      end
   end

   always_comb begin
      op_chain[0].valid = (state_ff == ST_ISSUE) && live_ff;
      op_chain[0].code  = code_ff;
      op_chain[0].col   = col_ff;
      op_chain[0].a_val = i8opa_pkg::lane_value(a_low_ff, a_high_ff,
                                                6'(step_ff[ROW_W-1:0]), a_sgn_ff);
   end

   assign addr_chain[0] = base_ff + step_ff;
   assign res_chain[0]  = '0;

   for (genvar j = 0; j < VECTOR_LEN; j++) begin : g_cell
      if (j < VECTOR_LEN - 1) begin : g_mid
         i8opa_cell #(
            .CELL_IDX (j),
            .DEPTH    (DEPTH),
            .ADDR_W   (ADDR_W)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .in_op    (op_chain[j]),
            .in_addr  (addr_chain[j]),
            .b_val    (i8opa_pkg::lane_value(b_low_ff, b_high_ff, 6'(j), b_sgn_ff)),
            .res_in   (res_chain[j]),
            .out_op   (op_chain[j+1]),
            .out_addr (addr_chain[j+1]),
            .res_out  (res_chain[j+1])
         );
      end else begin : g_last
         i8opa_cell #(
            .CELL_IDX (j),
            .DEPTH    (DEPTH),
            .ADDR_W   (ADDR_W)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .in_op    (op_chain[j]),
            .in_addr  (addr_chain[j]),
            .b_val    (i8opa_pkg::lane_value(b_low_ff, b_high_ff, 6'(j), b_sgn_ff)),
            .res_in   (res_chain[j]),
            .out_op   (),
            .out_addr (),
            .res_out  (res_chain[j+1])
         );
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_WAIT) && wait_done && respond_ff;
   assign rsp_value  = read_ff ? signed'(res_chain[VECTOR_LEN]) : '0;

endmodule
